/* sv/shellsort_key_sorter_assert.svh */
// Assertion macros shared by the key sorter RTL.
`ifndef SHELLSORT_KEY_SORTER_ASSERT_SVH
`define SHELLSORT_KEY_SORTER_ASSERT_SVH
`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define SKS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: sorter check failed");
// Checked property that must also hold during reset.
`define SKS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: sorter check failed");
`else
`define SKS_ASSERT(lbl, clk, rstn, prop)
`define SKS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* sv/sks_pkg.sv */
// Shared constants and types of the key sorter.
package sks_pkg;

  // Default sizes of the sorter.
  localparam int SKS_CAPACITY = 64;
  localparam int SKS_KEY_BITS = 32;

  // Fixed width of the key fields on the channels and of the APB data bus.
  localparam int SKS_FIELD_BITS = 32;
  localparam int SKS_APB_DATA_BITS = 32;
  localparam int SKS_APB_ADDR_BITS = 3;

  // Register index, taken from paddr bit 2.
  localparam logic SKS_REG_SIGNED_COMPARE = 1'b0;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic insert;      // a new key is placed into the row this cycle
    logic shift;       // the row moves one place toward the head
    logic signed_cmp;  // compare keys as two's complement numbers
  } sks_cell_ctrl_t;

endpackage

/* sv/sks_if.sv */
// Request channel interfaces for keys in and sorted keys out.
interface sks_in_if;
  import sks_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [SKS_FIELD_BITS-1:0] key_value;
  logic                      last_key;

  modport source (output valid, output key_value, output last_key, input ready);
  modport sink (input valid, input key_value, input last_key, output ready);
endinterface

interface sks_out_if;
  import sks_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [SKS_FIELD_BITS-1:0] sorted_key;
  logic                      last_out;
  logic                      dropped_flag;

  modport source (output valid, output sorted_key, output last_out, output dropped_flag,
                  input ready);
  modport sink (input valid, input sorted_key, input last_out, input dropped_flag,
                output ready);
endinterface

/* sv/sks_cell.sv */
// One cell of the sorting row: holds a key and trades keys with its neighbors.
module sks_cell #(
  parameter int KEY_BITS = 32
) (
  input  logic                   clk_i,
  input  sks_pkg::sks_cell_ctrl_t ctrl_i,
  input  logic [KEY_BITS-1:0]    new_key_i,
  input  logic                   occupied_i,
  input  logic [KEY_BITS-1:0]    left_key_i,
  input  logic                   left_gt_i,
  input  logic [KEY_BITS-1:0]    right_key_i,
  output logic [KEY_BITS-1:0]    key_o,
  output logic                   gt_o
);

  localparam logic [KEY_BITS-1:0] SignMask = {1'b1, {(KEY_BITS-1){1'b0}}};

  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_d;
  logic [KEY_BITS-1:0] held_cmp;
  logic [KEY_BITS-1:0] new_cmp;

  // Flipping the sign bit turns a signed compare into an unsigned one.
  assign held_cmp = ctrl_i.signed_cmp ? (key_q ^ SignMask) : key_q;
  assign new_cmp  = ctrl_i.signed_cmp ? (new_key_i ^ SignMask) : new_key_i;

  // An empty cell orders after every key.
  assign gt_o  = !occupied_i || (held_cmp > new_cmp);
  assign key_o = key_q;

  // The row stays sorted: cells past the insert point take their left neighbor.
  always_comb begin
    key_d = key_q;
    if (ctrl_i.insert) begin
      if (left_gt_i) begin
        key_d = left_key_i;
      end else if (gt_o) begin
        key_d = new_key_i;
      end
    end else if (ctrl_i.shift) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

/* sv/shellsort_key_sorter.sv */
// Top level of the key sorter: APB register, sequencer and the row of cells.
//
//   channel   direction  payload                                   accepted when
//   in_ch_i   in         key_value, last_key                       valid && ready
//   out_ch_o  out        sorted_key, last_out, dropped_flag        valid && ready
//   APB       in/out     signed_compare at byte 0                  psel && penable && pwrite
//
// A key is taken every cycle while a set loads; each key that fits is placed at once into
// its sorted position in the row of cells by one compare per cell; once the row is full a
// key is dropped and sets the overflow mark. After the last key the set drains from the
// head cell at one key per cycle while the output is ready.
// No new key is taken while a set drains. A stalled output holds the head cell.
// Reset clears the count, the overflow mark, the register and the sequencer state.
`include "shellsort_key_sorter_assert.svh"

module shellsort_key_sorter #(
  parameter int CAPACITY = sks_pkg::SKS_CAPACITY,
  parameter int KEY_BITS = sks_pkg::SKS_KEY_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  sks_in_if.sink                                 in_ch_i,
  sks_out_if.source                              out_ch_o,
  input  logic                                   psel_i,
  input  logic                                   penable_i,
  input  logic                                   pwrite_i,
  input  logic [sks_pkg::SKS_APB_ADDR_BITS-1:0]  paddr_i,
  input  logic [sks_pkg::SKS_APB_DATA_BITS-1:0]  pwdata_i,
  output logic [sks_pkg::SKS_APB_DATA_BITS-1:0]  prdata_o,
  output logic                                   pready_o
);
  import sks_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int ExtBits = (KEY_BITS > SKS_FIELD_BITS) ? KEY_BITS : SKS_FIELD_BITS;
  localparam logic [CW-1:0] Full = CW'(CAPACITY);
  localparam logic [CW-1:0] One = CW'(1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic            overflow_q;
  logic            signed_q;

  logic            in_fire;
  logic            out_fire;
  logic            store_full;
  logic            apb_write;
  sks_cell_ctrl_t  cell_ctrl;

  logic [ExtBits-1:0]  key_in_ext;
  logic [KEY_BITS-1:0] key_in;
  logic [ExtBits-1:0]  key_out_ext;

  logic [KEY_BITS-1:0] key_w [CAPACITY];
  logic                gt_w  [CAPACITY];

  // Configuration register.
  assign pready_o  = 1'b1;
  assign apb_write = psel_i && penable_i && pwrite_i;
  assign prdata_o  = (paddr_i[2] == SKS_REG_SIGNED_COMPARE) ?
                     SKS_APB_DATA_BITS'(signed_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q <= 1'b0;
    end else if (apb_write && (paddr_i[2] == SKS_REG_SIGNED_COMPARE)) begin
      signed_q <= pwdata_i[0];
    end
  end

  // Handshakes and the controls sent to every cell.
  assign in_ch_i.ready  = (state_q == ST_LOAD);
  assign out_ch_o.valid = (state_q == ST_DRAIN);
  assign in_fire        = in_ch_i.valid && in_ch_i.ready;
  assign out_fire       = out_ch_o.valid && out_ch_o.ready;
  assign store_full     = (count_q == Full);

  assign cell_ctrl.insert     = in_fire && !store_full;
  assign cell_ctrl.shift      = out_fire;
  assign cell_ctrl.signed_cmp = signed_q;

  // Keys keep only their low KEY_BITS bits; the output is widened or cut to 32 bits.
  assign key_in_ext  = ExtBits'(in_ch_i.key_value);
  assign key_in      = key_in_ext[KEY_BITS-1:0];
  assign key_out_ext = ExtBits'(key_w[0]);

  assign out_ch_o.sorted_key   = key_out_ext[SKS_FIELD_BITS-1:0];
  assign out_ch_o.last_out     = (count_q == One);
  assign out_ch_o.dropped_flag = overflow_q;

  // Sequencer: load a set, then drain it from the head of the row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (store_full) begin
              overflow_q <= 1'b1;
            end else begin
              count_q <= count_q + One;
            end
            if (in_ch_i.last_key) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_fire) begin
            count_q <= count_q - One;
            if (count_q == One) begin
              state_q    <= ST_LOAD;
              overflow_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  // The row of cells, kept in ascending order from the head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic                left_gt;
    logic [KEY_BITS-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_key = key_w[i];
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_key = key_w[i-1];
      assign left_gt  = gt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = key_w[i];
    end else begin : g_inner
      assign right_key = key_w[i+1];
    end

    sks_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .new_key_i  (key_in),
      .occupied_i (CW'(i) < count_q),
      .left_key_i (left_key),
      .left_gt_i  (left_gt),
      .right_key_i(right_key),
      .key_o      (key_w[i]),
      .gt_o       (gt_w[i])
    );
  end

  // Loading and draining never overlap.
  `SKS_ASSERT(a_load_drain_excl, clk_i, rst_ni, !(in_ch_i.ready && out_ch_o.valid))
  // A set that closes always has something to emit next.
  `SKS_ASSERT(a_last_starts_drain, clk_i, rst_ni, in_fire && in_ch_i.last_key |=> out_ch_o.valid && (count_q != '0))
  // The final sorted key returns the block to loading with a clean overflow mark.
  `SKS_ASSERT(a_end_of_set, clk_i, rst_ni, out_fire && out_ch_o.last_out |=> in_ch_i.ready && !overflow_q)
  // The count never passes the row length.
  `SKS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= Full)

endmodule
